@@ hdl/gbl_pkg.sv @@
// Shared types and constants for the glyph bitmap to LCD bus expander.
package gbl_pkg;

    localparam logic [15:0] CMD_COLUMN   = 16'h002A;
    localparam logic [15:0] CMD_PAGE     = 16'h002B;
    localparam logic [15:0] CMD_MEMWRITE = 16'h002C;
    localparam logic [15:0] BYTE_MASK    = 16'h00FF;

    typedef enum logic {
        KIND_START  = 1'b0,
        KIND_BITMAP = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] x;
        logic [15:0] xe;
        logic [15:0] y;
        logic [15:0] ye;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [7:0]  bits;
        logic [3:0]  count;
        logic        glyph_end;
    } job_t;

    typedef struct packed {
        logic        is_command;
        logic [15:0] bus_value;
        logic        last_of_run;
        logic        glyph_done;
    } word_t;

endpackage

@@ hdl/gbl_front.sv @@
// Front end: accepts input words, tracks glyph progress and queues jobs.
module gbl_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [87:0]        s_tdata,
    input  logic [0:0]         s_tuser,
    input  logic               q_full,
    output logic               q_push,
    output gbl_pkg::job_t      q_data
);

    logic [15:0] fg_reg, fg_next;
    logic [15:0] bg_reg, bg_next;
    logic [7:0]  width_reg, width_next;
    logic [7:0]  rows_reg, rows_next;
    logic [7:0]  col_reg, col_next;

    logic [15:0] pos_x, pos_y, fg_in, bg_in;
    logic [7:0]  w_in, h_in, byte_in;
    logic        accept, is_start, active, row_end;
    logic [7:0]  remain;
    logic [3:0]  count;

    assign pos_x   = s_tdata[15:0];
    assign pos_y   = s_tdata[31:16];
    assign w_in    = s_tdata[39:32];
    assign h_in    = s_tdata[47:40];
    assign fg_in   = s_tdata[63:48];
    assign bg_in   = s_tdata[79:64];
    assign byte_in = s_tdata[87:80];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_start = (gbl_pkg::kind_t'(s_tuser[0]) == gbl_pkg::KIND_START);
    assign active   = (rows_reg != 8'd0) && (width_reg != 8'd0);
    assign remain   = width_reg - col_reg;
    assign row_end  = (remain <= 8'd8);
    assign count    = row_end ? remain[3:0] : 4'd8;
    assign q_push   = accept && (is_start || active);

    always_comb
    begin
        q_data.kind      = is_start ? gbl_pkg::KIND_START : gbl_pkg::KIND_BITMAP;
        q_data.x         = pos_x;
        q_data.xe        = pos_x + {8'd0, w_in} - 16'd1;
        q_data.y         = pos_y;
        q_data.ye        = pos_y + {8'd0, h_in};
        q_data.fg        = fg_reg;
        q_data.bg        = bg_reg;
        q_data.bits      = byte_in;
        q_data.count     = count;
        q_data.glyph_end = row_end && (rows_reg == 8'd1);
    end

    always_comb
    begin
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        width_next = width_reg;
        rows_next  = rows_reg;
        col_next   = col_reg;
        if (accept)
        begin
            if (is_start)
            begin
                fg_next    = fg_in;
                bg_next    = bg_in;
                width_next = w_in;
                col_next   = 8'd0;
                rows_next  = (w_in == 8'd0) ? 8'd0 : h_in;
            end
            else if (active)
            begin
                if (row_end)
                begin
                    col_next  = 8'd0;
                    rows_next = rows_reg - 8'd1;
                end
                else
                begin
                    col_next = col_reg + {4'd0, count};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg    <= 16'd0;
            bg_reg    <= 16'd0;
            width_reg <= 8'd0;
            rows_reg  <= 8'd0;
            col_reg   <= 8'd0;
        end
        else
        begin
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            width_reg <= width_next;
            rows_reg  <= rows_next;
            col_reg   <= col_next;
        end
    end

endmodule

@@ hdl/gbl_fifo.sv @@
// Short job queue between the front end and the bus sequencer.
module gbl_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbl_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output gbl_pkg::job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gbl_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ hdl/gbl_back.sv @@
// Bus sequencer: expands queued jobs into command, address and pixel words.
module gbl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  gbl_pkg::job_t q_data,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output gbl_pkg::word_t m_word
);

    localparam logic [3:0] STEP_CMD_COL = 4'd0;
    localparam logic [3:0] STEP_X_HI    = 4'd1;
    localparam logic [3:0] STEP_X_LO    = 4'd2;
    localparam logic [3:0] STEP_XE_HI   = 4'd3;
    localparam logic [3:0] STEP_XE_LO   = 4'd4;
    localparam logic [3:0] STEP_CMD_PG  = 4'd5;
    localparam logic [3:0] STEP_Y_HI    = 4'd6;
    localparam logic [3:0] STEP_Y_LO    = 4'd7;
    localparam logic [3:0] STEP_YE_HI   = 4'd8;
    localparam logic [3:0] STEP_YE_LO   = 4'd9;
    localparam logic [3:0] STEP_CMD_MEM = 4'd10;

    gbl_pkg::job_t  job_reg;
    gbl_pkg::word_t word_reg, word_next;
    logic           job_valid_reg, job_valid_next;
    logic           out_valid_reg, out_valid_next;
    logic [3:0]     step_reg, step_next;
    logic [3:0]     final_step;
    logic           step_last, out_load;

    assign final_step = (job_reg.kind == gbl_pkg::KIND_START) ? STEP_CMD_MEM
                                                             : job_reg.count - 4'd1;
    assign step_last  = (step_reg == final_step);
    assign out_load   = job_valid_reg && (!out_valid_reg || m_tready);
    assign q_pop      = q_valid && (!job_valid_reg || (out_load && step_last));
    assign m_tvalid   = out_valid_reg;
    assign m_word     = word_reg;

    always_comb
    begin
        word_next = '0;
        if (job_reg.kind == gbl_pkg::KIND_START)
        begin
            unique case (step_reg)
                STEP_CMD_COL:
                begin
                    word_next.is_command = 1'b1;
                    word_next.bus_value  = gbl_pkg::CMD_COLUMN;
                end
                STEP_X_HI:  word_next.bus_value = job_reg.x >> 8;
                STEP_X_LO:  word_next.bus_value = job_reg.x & gbl_pkg::BYTE_MASK;
                STEP_XE_HI: word_next.bus_value = job_reg.xe >> 8;
                STEP_XE_LO: word_next.bus_value = job_reg.xe & gbl_pkg::BYTE_MASK;
                STEP_CMD_PG:
                begin
                    word_next.is_command = 1'b1;
                    word_next.bus_value  = gbl_pkg::CMD_PAGE;
                end
                STEP_Y_HI:  word_next.bus_value = job_reg.y >> 8;
                STEP_Y_LO:  word_next.bus_value = job_reg.y & gbl_pkg::BYTE_MASK;
                STEP_YE_HI: word_next.bus_value = job_reg.ye >> 8;
                STEP_YE_LO: word_next.bus_value = job_reg.ye & gbl_pkg::BYTE_MASK;
                STEP_CMD_MEM:
                begin
                    word_next.is_command  = 1'b1;
                    word_next.bus_value   = gbl_pkg::CMD_MEMWRITE;
                    word_next.last_of_run = 1'b1;
                end
                default: word_next = '0;
            endcase
        end
        else
        begin
            word_next.bus_value   = job_reg.bits[~step_reg[2:0]] ? job_reg.fg : job_reg.bg;
            word_next.last_of_run = step_last;
            word_next.glyph_done  = step_last && job_reg.glyph_end;
        end
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            job_valid_next = 1'b1;
            step_next      = 4'd0;
        end
        else if (out_load)
        begin
            if (step_last)
            begin
                job_valid_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 4'd1;
            end
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= 4'd0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        if (out_load)
        begin
            word_reg <= word_next;
        end
    end

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (step_reg <= final_step))
        else $error("sequencer step beyond end of job");

    a_done_is_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && word_reg.glyph_done) |->
            (word_reg.last_of_run && !word_reg.is_command))
        else $error("glyph done on a word that is not a final pixel");

    a_cmd_last_is_memwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && word_reg.is_command && word_reg.last_of_run) |->
            (word_reg.bus_value == gbl_pkg::CMD_MEMWRITE))
        else $error("window sequence ends on a wrong command");

endmodule

@@ hdl/glyph_bitmap_to_lcd_bus_top.sv @@
// Top level of the glyph bitmap to LCD bus expander.
//
// Input stream (s_axis): tuser is the word kind. A start word opens a glyph and
// produces the eleven-word window sequence (column command and bytes, page command
// and bytes, memory write command). A bitmap word expands into up to eight RGB565
// pixel words, MSB first; a row always ends on a byte, and bitmap words outside an
// active glyph produce nothing.
// Output stream (m_axis): one bus write per word; tuser marks commands and the
// final pixel of the glyph, tlast marks the last word caused by one input word.
// An accepted input word is queued in the job FIFO, then loaded into the
// sequencer job register; each output word is registered before it drives m_axis.
// The bus sequencer emits one word per cycle while it holds a job and
// m_axis_tready is high; dropped bitmap words never reach the sequencer. The
// front end keeps accepting while the job queue (FIFO_DEPTH entries) has room.
// Reset clears the glyph state, the queue and the output valid flag; no glyph is
// active after reset. When m_axis_tready is low the output word holds, the
// sequencer stops, and s_axis_tready falls once the queue fills.
module glyph_bitmap_to_lcd_bus_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x[15:0], pos_y[31:16], glyph_width[39:32], glyph_height[47:40],
    // fg_color[63:48], bg_color[79:64], bitmap_byte[87:80]
    input  logic [87:0] s_axis_tdata,
    // kind[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bus_value[15:0]
    output logic [15:0] m_axis_tdata,
    // is_command[0], glyph_done[1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    gbl_pkg::job_t  push_job, pop_job;
    gbl_pkg::word_t out_word;
    logic           q_push, q_full, q_valid, q_pop;

    gbl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_job)
    );

    gbl_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_job)
    );

    gbl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_word   (out_word)
    );

    assign m_axis_tdata = out_word.bus_value;
    assign m_axis_tuser = {out_word.glyph_done, out_word.is_command};
    assign m_axis_tlast = out_word.last_of_run;

endmodule
